/* rtl/core/n2a_pkg.sv */
// Shared constants, codes and helpers for the number-to-ASCII text emitter.
package n2a_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int BIN_W   = 32;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W   = 4 * DEC_DIGITS;

    localparam logic [OP_W-1:0] OP_HEX8  = 3'd0;
    localparam logic [OP_W-1:0] OP_HEX16 = 3'd1;
    localparam logic [OP_W-1:0] OP_HEX32 = 3'd2;
    localparam logic [OP_W-1:0] OP_HEX64 = 3'd3;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd4;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef logic [CHAR_W-1:0] t_char;

    // Lower-case hex digit for one nibble; also serves BCD digits.
    function automatic t_char digit_char(input logic [3:0] nib);
        t_char c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'b0000, nib};
        end else begin
            c = CH_LOWER_A + {4'b0000, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

/* rtl/core/n2a_if.sv */
// Valid/ready channel interfaces for input items and output characters.
interface n2a_in_if;
    logic                          valid;
    logic                          ready;
    logic [n2a_pkg::OP_W-1:0]      op;
    logic [n2a_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface n2a_out_if;
    logic                          valid;
    logic                          ready;
    logic [n2a_pkg::CHAR_W-1:0]    text_char;
    logic                          last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

/* rtl/core/n2a_bcd_conv.sv */
// Iterative binary-to-BCD converter: one shift-and-adjust step per cycle.
module n2a_bcd_conv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [n2a_pkg::BIN_W-1:0]  i_bin,
    output logic                       o_done,
    output logic [n2a_pkg::BCD_W-1:0]  o_bcd
);
    import n2a_pkg::*;

    localparam int CNT_W = $clog2(BIN_W);

    logic [BIN_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [BCD_W-1:0] adj;

    // add 3 to every digit of 5 or more, then shift the next bit in
    always_comb begin
        for (int d = 0; d < DEC_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
        n_bcd = {adj[BCD_W-2:0], r_bin[BIN_W-1]};
        n_bin = {r_bin[BIN_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

/* rtl/core/number_to_ascii_text_emitter_top.sv */
// Top level: formats one value as hex or decimal ASCII, one character per transaction.
// Hex: after the input transaction, one character per cycle while the output is taken.
// Decimal: the BCD shift/adjust unit is loaded and run, leading zeros are dropped, keeping
//   at least one digit, then one character per cycle while the output is taken.
// Input ready only while idle. Synchronous active-low reset clears control state and
//   sets the append-newline flag r_nl to 1.
module number_to_ascii_text_emitter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    n2a_in_if.sink               i_in,
    n2a_out_if.source            o_out,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data
);
    import n2a_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SKIP = 3'd2;
    localparam logic [2:0] S_PFX0 = 3'd3;
    localparam logic [2:0] S_PFXX = 3'd4;
    localparam logic [2:0] S_DIG  = 3'd5;
    localparam logic [2:0] S_NL   = 3'd6;

    localparam int NIB_CNT_W = 5;

    logic [2:0]           r_state;
    logic [VALUE_W-1:0]   r_data;
    logic [NIB_CNT_W-1:0] r_cnt;
    logic                 r_nl;
    logic                 r_out_valid;
    t_char                r_out_char;
    logic                 r_out_last;

    logic                 in_acc;
    logic                 can_emit;
    logic                 conv_start;
    logic                 conv_done;
    logic [BCD_W-1:0]     conv_bcd;
    logic [VALUE_W-1:0]   hex_aligned;
    logic                 emit;
    t_char                emit_char;
    logic                 emit_last;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign can_emit    = !r_out_valid || o_out.ready;
    assign conv_start  = in_acc && (i_in.op == OP_DEC);

    n2a_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_bin   (i_in.value[BIN_W-1:0]),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    // put the used nibbles at the top of the shift register
    always_comb begin
        case (i_in.op)
            OP_HEX8:  hex_aligned = {i_in.value[7:0],  56'd0};
            OP_HEX16: hex_aligned = {i_in.value[15:0], 48'd0};
            OP_HEX32: hex_aligned = {i_in.value[31:0], 32'd0};
            default:  hex_aligned = i_in.value;
        endcase
    end

    always_comb begin
        emit      = 1'b0;
        emit_char = CH_ZERO;
        emit_last = 1'b0;
        case (r_state)
            S_PFX0: begin
                emit = can_emit;
            end
            S_PFXX: begin
                emit      = can_emit;
                emit_char = CH_X;
            end
            S_DIG: begin
                emit      = can_emit;
                emit_char = digit_char(r_data[VALUE_W-1 -: 4]);
                emit_last = (r_cnt == NIB_CNT_W'(1)) && !r_nl;
            end
            S_NL: begin
                emit      = can_emit;
                emit_char = CH_NEWLINE;
                emit_last = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nl        <= 1'b1;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_nl <= i_cfg_wr_data;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.op < OP_DEC) begin
                            r_cnt   <= NIB_CNT_W'(2) << i_in.op[1:0];
                            r_state <= S_PFX0;
                        end else if (i_in.op == OP_DEC) begin
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        r_cnt   <= NIB_CNT_W'(DEC_DIGITS);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // drop leading zeros, keep at least one digit
                    if (r_data[VALUE_W-1 -: 4] == 4'd0 && r_cnt > NIB_CNT_W'(1)) begin
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_state <= S_DIG;
                    end
                end
                S_PFX0: begin
                    if (emit) begin
                        r_state <= S_PFXX;
                    end
                end
                S_PFXX: begin
                    if (emit) begin
                        r_state <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (emit) begin
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == NIB_CNT_W'(1)) begin
                            r_state <= r_nl ? S_NL : S_IDLE;
                        end
                    end
                end
                S_NL: begin
                    if (emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: nibble shift register and output character
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_data <= hex_aligned;
        end else if (r_state == S_CONV && conv_done) begin
            r_data <= {conv_bcd, {(VALUE_W - BCD_W){1'b0}}};
        end else if (r_state == S_SKIP && r_data[VALUE_W-1 -: 4] == 4'd0
                     && r_cnt > NIB_CNT_W'(1)) begin
            r_data <= {r_data[VALUE_W-5:0], 4'd0};
        end else if (r_state == S_DIG && emit) begin
            r_data <= {r_data[VALUE_W-5:0], 4'd0};
        end

        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.text_char = r_out_char;
    assign o_out.last_char = r_out_last;

    a_dig_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG || r_state == S_SKIP) |-> (r_cnt != '0))
        else $error("digit count empty while emitting digits");

    a_conv_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_done |-> (r_state == S_CONV))
        else $error("BCD conversion finished outside CONV state");

    a_bad_op_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.op > OP_DEC) |=> (r_state == S_IDLE))
        else $error("unused format left idle state");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == S_IDLE))
        else $error("final character emitted before item finished");

endmodule
